FILE: rtl/core/nmea_pkg.sv
// Package for the NMEA sentence field parser core.
// Holds sentence kinds, field codes, parse phases and field types; no dependencies.
package nmea_pkg;

   localparam int FracDigitsDefault = 4;
   localparam int SatSlotsDefault   = 12;

   localparam logic [30:0] WholeMax = 31'h7FFF_FFFF;

   typedef enum logic [1:0] {
      KIND_UNKNOWN = 2'd0,
      KIND_RMC     = 2'd1,
      KIND_GGA     = 2'd2,
      KIND_GSA     = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_WHOLE = 3'd0,
      PH_FRAC  = 3'd1,
      PH_DONE  = 3'd2,
      PH_BAD   = 3'd3,
      PH_START = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      FT_NONE  = 3'd0,
      FT_INT   = 3'd1,
      FT_CHAR  = 3'd2,
      FT_FIXED = 3'd3,
      FT_COORD = 3'd4,
      FT_PAIRS = 3'd5
   } ftype_type;

   localparam logic [4:0] CodeHour    = 5'd0;
   localparam logic [4:0] CodeStatus  = 5'd3;
   localparam logic [4:0] CodeLat     = 5'd4;
   localparam logic [4:0] CodeNs      = 5'd5;
   localparam logic [4:0] CodeLon     = 5'd6;
   localparam logic [4:0] CodeEw      = 5'd7;
   localparam logic [4:0] CodeSpeed   = 5'd8;
   localparam logic [4:0] CodeCourse  = 5'd9;
   localparam logic [4:0] CodeDay     = 5'd10;
   localparam logic [4:0] CodeFix     = 5'd13;
   localparam logic [4:0] CodeSats    = 5'd14;
   localparam logic [4:0] CodeMode1   = 5'd15;
   localparam logic [4:0] CodeMode2   = 5'd16;
   localparam logic [4:0] CodeSat     = 5'd17;
   localparam logic [4:0] CodePdop    = 5'd18;
   localparam logic [4:0] CodeEnd     = 5'd21;

   localparam logic [7:0] ChDollar = 8'h24;
   localparam logic [7:0] ChComma  = 8'h2C;
   localparam logic [7:0] ChDot    = 8'h2E;
   localparam logic [7:0] ChCr     = 8'h0D;

   // one pending result
   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  code;
      logic [3:0]  slot;
      logic [30:0] whole;
      logic [6:0]  mins;
      logic [13:0] frac;
      logic [7:0]  letter;
      logic        ok;
      logic        last;
   } result_type;

endpackage

FILE: rtl/core/nmea_sentence_field_parser_core.sv
// NMEA sentence field parser core, top level.
// Depends on nmea_pkg.
//
// Usage:
//  req_ channel carries one received byte (req_rx_byte) per transfer.
//  rsp_ channel carries one field result per transfer; a byte may cause
//  zero to four results (three time/date parts plus the end marker).
//  A byte is taken into the parse state in the cycle it is accepted; the
//  results it causes are written into a four-entry result queue at the
//  same edge and appear on rsp_ from the next cycle, one per cycle unless stalled.
//  req_ready is high when the queue is empty, or holds one result that
//  transfers in the same cycle. A byte that yields results therefore holds
//  the input until the queue is down to its last result and that result
//  transfers; bytes that yield no result go back to back.
//  A stalled receiver holds rsp_ data steady and blocks new bytes once
//  results are pending.
//  Reset (synchronous, active high) leaves the parser outside a sentence
//  with an empty queue.
module nmea_sentence_field_parser_core
   #(parameter int FRAC_DIGITS = nmea_pkg::FracDigitsDefault,
     parameter int SAT_SLOTS   = nmea_pkg::SatSlotsDefault)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [7:0]  req_rx_byte,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  rsp_sentence_kind,
    output logic [4:0]  rsp_field_code,
    output logic [3:0]  rsp_slot_index,
    output logic [30:0] rsp_whole_value,
    output logic [6:0]  rsp_minutes_value,
    output logic [13:0] rsp_frac_value,
    output logic [7:0]  rsp_letter,
    output logic        rsp_ok,
    output logic        rsp_last);

   import nmea_pkg::*;

   localparam logic [2:0] FracLim = 3'(FRAC_DIGITS);
   localparam logic [4:0] SatLo   = 5'd3;
   localparam logic [4:0] SatEnd  = 5'(3 + SAT_SLOTS);

   // parse state
   logic        in_sent_ff, in_sent_in;
   logic [7:0]  hdr_ff [4], hdr_in [4];
   logic [2:0]  pos_ff, pos_in;
   kind_type    kind_ff, kind_in;
   logic [4:0]  fnum_ff, fnum_in;
   logic [30:0] whole_ff, whole_in;
   logic [13:0] frac_ff, frac_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   phase_type   phase_ff, phase_in;
   logic [7:0]  letter_ff, letter_in;
   logic [6:0]  pair_ff [3], pair_in [3];

   // result queue
   result_type  q_ff [4], q_in [4];
   logic [2:0]  qcnt_ff, qcnt_in;

   logic        take;
   assign req_ready = (qcnt_ff == 3'd0) || ((qcnt_ff == 3'd1) && rsp_ready);
   assign take      = req_valid && req_ready;
   assign rsp_valid = (qcnt_ff != 3'd0);

   assign rsp_sentence_kind = q_ff[0].kind;
   assign rsp_field_code    = q_ff[0].code;
   assign rsp_slot_index    = q_ff[0].slot;
   assign rsp_whole_value   = q_ff[0].whole;
   assign rsp_minutes_value = q_ff[0].mins;
   assign rsp_frac_value    = q_ff[0].frac;
   assign rsp_letter        = q_ff[0].letter;
   assign rsp_ok            = q_ff[0].ok;
   assign rsp_last          = q_ff[0].last;

   // field classification
   ftype_type   ftype;
   logic [4:0]  fcode;
   logic [3:0]  fslot;
   always_comb begin
      ftype = FT_NONE;
      fcode = CodeHour;
      fslot = 4'd0;
      unique case (kind_ff)
         KIND_RMC: begin
            unique case (fnum_ff)
               5'd1: begin ftype = FT_PAIRS; fcode = CodeHour;   end
               5'd2: begin ftype = FT_CHAR;  fcode = CodeStatus; end
               5'd3: begin ftype = FT_COORD; fcode = CodeLat;    end
               5'd4: begin ftype = FT_CHAR;  fcode = CodeNs;     end
               5'd5: begin ftype = FT_COORD; fcode = CodeLon;    end
               5'd6: begin ftype = FT_CHAR;  fcode = CodeEw;     end
               5'd7: begin ftype = FT_FIXED; fcode = CodeSpeed;  end
               5'd8: begin ftype = FT_FIXED; fcode = CodeCourse; end
               5'd9: begin ftype = FT_PAIRS; fcode = CodeDay;    end
               default: ;
            endcase
         end
         KIND_GGA: begin
            if (fnum_ff == 5'd6) begin
               ftype = FT_INT; fcode = CodeFix;
            end else if (fnum_ff == 5'd7) begin
               ftype = FT_INT; fcode = CodeSats;
            end
         end
         KIND_GSA: begin
            if (fnum_ff == 5'd1) begin
               ftype = FT_CHAR; fcode = CodeMode1;
            end else if (fnum_ff == 5'd2) begin
               ftype = FT_INT; fcode = CodeMode2;
            end else if (fnum_ff >= SatLo && fnum_ff < SatEnd) begin
               ftype = FT_INT; fcode = CodeSat;
               fslot = 4'(fnum_ff - SatLo);
            end else if (fnum_ff >= SatEnd && fnum_ff <= SatEnd + 5'd2) begin
               ftype = FT_FIXED;
               fcode = CodePdop + (fnum_ff - SatEnd);
            end
         end
         default: ;
      endcase
   end

   // field finish values: divides by ten and a hundred by reciprocal multiply
   logic        fixed_ok;
   logic [13:0] frac_adj;
   logic [29:0] fprod;
   logic [30:0] deg;
   logic [6:0]  minv;
   logic [61:0] dprod;
   logic [31:0] rem;
   always_comb begin
      fixed_ok = (phase_ff == PH_FRAC) || (phase_ff == PH_DONE);
      // floor(x/10) = (x * ceil(2^19/10)) >> 19 for x < 2^14
      fprod    = 30'(frac_ff) * 30'd52429;
      frac_adj = (fcnt_ff == 3'd2) ? 14'(fprod >> 19) : frac_ff;
      // floor(x/100) = (x * ceil(2^37/100)) >> 37 for x < 2^31
      dprod = 62'(whole_ff) * 62'd1374389535;
      deg   = 31'(dprod >> 37);
      rem   = 32'(whole_ff) - 32'(deg) * 32'd100;
      minv  = rem[6:0];
   end

   // finished-field results
   result_type  fres [3];
   logic [1:0]  fn_cnt;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fres[i]      = '0;
         fres[i].kind = kind_ff;
      end
      fn_cnt = 2'd0;
      unique case (ftype)
         FT_PAIRS: begin
            fn_cnt = 2'd3;
            for (int i = 0; i < 3; i++) begin
               fres[i].code  = fcode + 5'(i);
               fres[i].whole = 31'(pair_ff[i]);
               fres[i].ok    = 1'b1;
            end
         end
         FT_INT: begin
            fn_cnt = 2'd1;
            fres[0].code  = fcode;
            fres[0].slot  = fslot;
            fres[0].whole = whole_ff;
            fres[0].ok    = 1'b1;
         end
         FT_CHAR: begin
            fn_cnt = 2'd1;
            fres[0].code   = fcode;
            fres[0].letter = letter_ff;
            fres[0].ok     = (letter_ff != 8'd0);
         end
         FT_FIXED, FT_COORD: begin
            fn_cnt = 2'd1;
            fres[0].code = fcode;
            if (fixed_ok) begin
               fres[0].ok    = 1'b1;
               fres[0].frac  = frac_adj;
               fres[0].whole = (ftype == FT_COORD) ? deg : whole_ff;
               fres[0].mins  = (ftype == FT_COORD) ? minv : 7'd0;
            end
         end
         default: ;
      endcase
   end

   // byte handling and queue update
   logic       is_digit;
   logic [3:0] dig;
   logic [34:0] wmul;
   result_type endm;
   phase_type  ph;
   logic [1:0] pidx;
   always_comb begin
      in_sent_in = in_sent_ff;
      hdr_in     = hdr_ff;
      pos_in     = pos_ff;
      kind_in    = kind_ff;
      fnum_in    = fnum_ff;
      whole_in   = whole_ff;
      frac_in    = frac_ff;
      fcnt_in    = fcnt_ff;
      phase_in   = phase_ff;
      letter_in  = letter_ff;
      pair_in    = pair_ff;
      q_in       = q_ff;
      qcnt_in    = qcnt_ff;
      is_digit   = (req_rx_byte >= 8'h30) && (req_rx_byte <= 8'h39);
      dig        = 4'(req_rx_byte - 8'h30);
      wmul       = 35'(whole_ff) * 35'd10 + 35'(dig);
      pidx       = 2'(fcnt_ff >> 1);
      ph         = phase_ff;
      endm       = '0;
      endm.kind  = kind_ff;
      endm.code  = CodeEnd;
      endm.last  = 1'b1;

      // drain one result
      if (rsp_valid && rsp_ready) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
         q_in[2] = q_ff[3];
         qcnt_in = qcnt_ff - 3'd1;
      end

      if (take) begin
         priority if (req_rx_byte == ChDollar) begin
            in_sent_in = 1'b1;
            pos_in     = 3'd1;
            kind_in    = KIND_UNKNOWN;
            fnum_in    = 5'd0;
            whole_in = '0; frac_in = '0; fcnt_in = '0; letter_in = '0;
            pair_in  = '{default: '0};
            phase_in = PH_START;
         end else if (!in_sent_ff) begin
         end else if (req_rx_byte == ChCr) begin
            in_sent_in = 1'b0;
            if (pos_ff == 3'd6) begin
               for (int i = 0; i < 3; i++) q_in[i] = fres[i];
               q_in[fn_cnt] = endm;
               qcnt_in = 3'(fn_cnt) + 3'd1;
            end else begin
               q_in[0] = endm;
               qcnt_in = 3'd1;
            end
         end else if (pos_ff != 3'd6) begin
            if (pos_ff < 3'd5) hdr_in[2'(pos_ff - 3'd1)] = req_rx_byte;
            pos_in = pos_ff + 3'd1;
            if (pos_ff == 3'd5) begin
               if (hdr_ff[0] == "G" && hdr_ff[1] == "P" && hdr_ff[2] == "R" &&
                   hdr_ff[3] == "M" && req_rx_byte == "C")
                  kind_in = KIND_RMC;
               else if (hdr_ff[0] == "G" && hdr_ff[1] == "P" && hdr_ff[2] == "G"
                        && hdr_ff[3] == "G" && req_rx_byte == "A")
                  kind_in = KIND_GGA;
               else if (hdr_ff[0] == "G" && hdr_ff[1] == "P" && hdr_ff[2] == "G"
                        && hdr_ff[3] == "S" && req_rx_byte == "A")
                  kind_in = KIND_GSA;
               else
                  kind_in = KIND_UNKNOWN;
            end
         end else if (req_rx_byte == ChComma) begin
            for (int i = 0; i < 3; i++) q_in[i] = fres[i];
            qcnt_in = 3'(fn_cnt);
            if (fnum_ff != 5'd31) fnum_in = fnum_ff + 5'd1;
            whole_in = '0; frac_in = '0; fcnt_in = '0; letter_in = '0;
            pair_in  = '{default: '0};
            phase_in = PH_START;
         end else begin
            // field character
            if (ph == PH_START) begin
               if (req_rx_byte >= "A" && req_rx_byte <= "Z")
                  letter_in = req_rx_byte;
               ph = PH_WHOLE;
               phase_in = PH_WHOLE;
            end
            if (ph == PH_WHOLE) begin
               if (is_digit) begin
                  whole_in = (wmul > 35'(WholeMax)) ? WholeMax : wmul[30:0];
                  if (fcnt_ff < 3'd6)
                     pair_in[pidx] = 7'(8'(pair_ff[pidx]) * 8'd10 + 8'(dig));
                  if (fcnt_ff < 3'd7) fcnt_in = fcnt_ff + 3'd1;
               end else if (req_rx_byte == ChDot) begin
                  phase_in = PH_FRAC;
                  fcnt_in  = 3'd0;
               end else begin
                  phase_in = PH_BAD;
               end
            end else if (ph == PH_FRAC) begin
               if (is_digit && fcnt_ff < FracLim) begin
                  frac_in = 14'(frac_ff * 14'd10 + 14'(dig));
                  fcnt_in = fcnt_ff + 3'd1;
                  if (fcnt_ff + 3'd1 >= FracLim) phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DONE;
               end
            end
         end
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_sent_ff <= 1'b0;
         pos_ff     <= 3'd0;
         kind_ff    <= KIND_UNKNOWN;
         fnum_ff    <= 5'd0;
         whole_ff   <= '0;
         frac_ff    <= '0;
         fcnt_ff    <= '0;
         phase_ff   <= PH_WHOLE;
         letter_ff  <= '0;
         pair_ff    <= '{default: '0};
         qcnt_ff    <= 3'd0;
      end else begin
         in_sent_ff <= in_sent_in;
         pos_ff     <= pos_in;
         kind_ff    <= kind_in;
         fnum_ff    <= fnum_in;
         whole_ff   <= whole_in;
         frac_ff    <= frac_in;
         fcnt_ff    <= fcnt_in;
         phase_ff   <= phase_in;
         letter_ff  <= letter_in;
         pair_ff    <= pair_in;
         qcnt_ff    <= qcnt_in;
      end
      hdr_ff <= hdr_in;
      q_ff   <= q_in;
   end

endmodule
